>>> rtl/spark_tachometer_median_filter_defines.svh
// assertion macros for the spark tachometer checker
`ifndef SPARK_TACHOMETER_MEDIAN_FILTER_DEFINES_SVH
`define SPARK_TACHOMETER_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication, off during reset
`define SPTACH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sptach check failed");

// next-cycle implication, off during reset
`define SPTACH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sptach check failed");

`endif

>>> rtl/sptach_pkg.sv
`timescale 1ns / 1ps

package sptach_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // field and register widths
  localparam int TS_W       = 32;
  localparam int CPU_W      = 10;
  localparam int MIN_W      = 20;
  localparam int TMO_W      = 27;
  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int RPM_OUT_W  = 16;
  localparam int SAMP_W     = 26;   // 60000000 fits in 26 bits
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CPU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TMO = 2'd2;

  // register reset values
  localparam logic [CPU_W-1:0] CPU_RST = 10'd360;
  localparam logic [MIN_W-1:0] MIN_RST = 20'd3000;
  localparam logic [TMO_W-1:0] TMO_RST = 27'd1000000;

  localparam logic [DIV_W-1:0] RPM_NUM = 32'd60000000;

  localparam int SAMPLE_COUNT_DEF = 30;

  // controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted item
    logic div_load;     // start a division
    logic div_src_rpm;  // 0: interval / cycles_per_us, 1: numerator / us
    logic div_step;     // one quotient bit
    logic set_last;     // record the spark time
    logic do_start;
    logic do_stop;
    logic do_insert;
    logic load_out;
    logic out_stopped;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic running;
    logic us_gt_min;
    logic us_gt_timeout;
  } dp_stat_t;

endpackage

>>> rtl/sptach_ctrl.sv
`timescale 1ns / 1ps

module sptach_ctrl
  import sptach_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_DIV_US  = 7'b0000100,
    S_CHECK   = 7'b0001000,
    S_DIV_RPM = 7'b0010000,
    S_INSERT  = 7'b0100000,
    S_RESULT  = 7'b1000000
  } state_t;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    stopped_nxt = stopped_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_EDGE, CMD_READ: begin
            if (stat.running) begin
              cmd.div_load = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = S_DIV_US;
            end else if (stat.cmd == CMD_READ) begin
              stopped_nxt = 1'b1;
              state_nxt   = S_RESULT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          CMD_START: begin
            cmd.do_start = !stat.running;
            state_nxt    = S_IDLE;
          end
          CMD_STOP: begin
            cmd.do_stop = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV_US: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.cmd == CMD_EDGE) begin
          if (stat.us_gt_min) begin
            cmd.div_load    = 1'b1;
            cmd.div_src_rpm = 1'b1;
            cmd.set_last    = 1'b1;
            cnt_nxt         = '0;
            state_nxt       = S_DIV_RPM;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          stopped_nxt = stat.us_gt_timeout;
          state_nxt   = S_RESULT;
        end
      end
      S_DIV_RPM: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.do_insert = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out    = 1'b1;
          cmd.out_stopped = stopped_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/sptach_dp.sv
`timescale 1ns / 1ps

module sptach_dp
  import sptach_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_cmd,
  input  logic [TS_W-1:0]       in_now_cycles,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [RPM_OUT_W-1:0]  out_rpm,
  output logic                  out_stopped
);

  localparam int MID = SAMPLE_COUNT / 2;

  // configuration
  logic [CPU_W-1:0] cpu_r;
  logic [MIN_W-1:0] min_r;
  logic [TMO_W-1:0] tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r <= CPU_RST;
      min_r <= MIN_RST;
      tmo_r <= TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_CPU: cpu_r <= cfg_wdata[CPU_W-1:0];
        CFG_IDX_MIN: min_r <= cfg_wdata[MIN_W-1:0];
        CFG_IDX_TMO: tmo_r <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  cmd_t            cmd_r;
  logic [TS_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= cmd_t'(in_cmd);
      now_r <= in_now_cycles;
    end
  end

  // shared restoring divider, one quotient bit per step
  logic [DIV_W-1:0] quo_r, rem_r, dsr_r;
  logic [DIV_W:0]   rem_sh;
  logic             rem_ge;
  logic [DIV_W-1:0] rem_nxt, quo_nxt;
  logic [DIV_W-1:0] ld_dividend, ld_divisor;
  logic [TS_W-1:0]  last_r;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt = rem_ge ? DIV_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIV_W-1:0];
  assign quo_nxt = {quo_r[DIV_W-2:0], rem_ge};

  always_comb begin
    if (cmd.div_src_rpm) begin
      ld_dividend = RPM_NUM;
      ld_divisor  = quo_r;
    end else begin
      ld_dividend = now_r - last_r;
      ld_divisor  = (cpu_r == '0) ? DIV_W'(1) : {{(DIV_W-CPU_W){1'b0}}, cpu_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= ld_dividend;
      dsr_r <= ld_divisor;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // sorted sample row: each cell compares the new sample with its own value
  logic [SAMP_W-1:0]       samp_r   [SAMPLE_COUNT];
  logic [SAMP_W-1:0]       samp_nxt [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] gt;
  logic [SAMP_W-1:0]       new_v;
  logic                    low_half;

  assign new_v    = quo_r[SAMP_W-1:0];
  assign low_half = !gt[MID-1];

  for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_cell
    logic              below_gt, above_gt;
    logic [SAMP_W-1:0] below_v, above_v;

    assign gt[g] = (new_v > samp_r[g]);

    if (g == 0) begin : g_first
      assign below_gt = 1'b1;
      assign below_v  = new_v;
    end else begin : g_below
      assign below_gt = gt[g-1];
      assign below_v  = samp_r[g-1];
    end

    if (g == SAMPLE_COUNT - 1) begin : g_last
      assign above_gt = 1'b0;
      assign above_v  = samp_r[g];
    end else begin : g_above
      assign above_gt = gt[g+1];
      assign above_v  = samp_r[g+1];
    end

    // lower half: shift up above the slot; upper half: shift down below it
    always_comb begin
      if (low_half) begin
        samp_nxt[g] = gt[g] ? samp_r[g] : (below_gt ? new_v : below_v);
      end else begin
        samp_nxt[g] = above_gt ? above_v : (gt[g] ? new_v : samp_r[g]);
      end
    end
  end

  // engine state
  logic              running_r;
  logic [SAMP_W-1:0] prev_r;
  logic [SAMP_W:0]   avg_sum;
  logic [SAMP_W-1:0] avg;

  assign avg_sum = {1'b0, prev_r} + {1'b0, samp_r[MID]};
  assign avg     = avg_sum[SAMP_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.do_start) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) samp_r[i] <= '0;
    end else if (cmd.do_insert) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) samp_r[i] <= samp_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      prev_r    <= '0;
      last_r    <= '0;
    end else begin
      if (cmd.do_start) begin
        running_r <= 1'b1;
        prev_r    <= '0;
        last_r    <= now_r;
      end else if (cmd.do_stop) begin
        running_r <= 1'b0;
      end
      if (cmd.set_last) last_r <= now_r;
      if (cmd.load_out && !cmd.out_stopped) prev_r <= avg;
    end
  end

  // result register
  logic [RPM_OUT_W-1:0] rpm_r;
  logic                 stopped_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      stopped_r <= cmd.out_stopped;
      if (cmd.out_stopped) begin
        rpm_r <= '0;
      end else if (|avg[SAMP_W-1:RPM_OUT_W]) begin
        rpm_r <= '1;
      end else begin
        rpm_r <= avg[RPM_OUT_W-1:0];
      end
    end
  end

  assign out_rpm     = rpm_r;
  assign out_stopped = stopped_r;

  assign stat.cmd           = cmd_r;
  assign stat.running       = running_r;
  assign stat.us_gt_min     = (quo_r > {{(DIV_W-MIN_W){1'b0}}, min_r});
  assign stat.us_gt_timeout = (quo_r > {{(DIV_W-TMO_W){1'b0}}, tmo_r});

endmodule

>>> rtl/spark_tachometer_median_filter.sv
`timescale 1ns / 1ps
// spark tachometer with a sorted median filter
// input channel (in_valid / in_stall): one item is a command and a timestamp
//   from a free-running cycle counter; edge, read, start or stop
// result channel (out_valid / out_stall): a read gives one item, rpm and the
//   stopped flag; edge, start and stop give none
// config port (cfg_we / cfg_index / cfg_wdata): cycles_per_us, min_interval_us
//   and stall_timeout_us; user writes only while the block is idle, unenforced
// timing: one item at a time; in_stall is high from the cycle after accept
//   start / stop: in_stall high only while in the decode state after accept
//   read while inactive: decode, then the result state loads the output register
//   read while running: decode, 32-step interval divide, check, then result
//   accepted spark edge: two 32-step divides plus insert
//   the shared restoring divider (one quotient bit per cycle) does the divides
// the sample row inserts a new rpm value in the insert state, a compare per cell
// output register: a result waits in it while the receiver stalls and the
//   next item is still taken; a later read holds until the register frees
// reset (rst_n low, synchronous): registers back to defaults, samples and
//   history cleared, block inactive, no result pending

module spark_tachometer_median_filter
  import sptach_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [TS_W-1:0]       in_now_cycles,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RPM_OUT_W-1:0]  out_rpm,
  output logic                  out_stopped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: decode, divider steps, insert, result hand-off
  sptach_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // registers, divider, sample row and result register
  sptach_dp #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_now_cycles (in_now_cycles),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .out_rpm       (out_rpm),
    .out_stopped   (out_stopped)
  );

endmodule

>>> rtl/sptach_chk.sv
`timescale 1ns / 1ps
`include "spark_tachometer_median_filter_defines.svh"

module sptach_chk
  import sptach_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            in_cmd,
  input logic [TS_W-1:0]       in_now_cycles,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [RPM_OUT_W-1:0]  out_rpm,
  input logic                  out_stopped,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a stopped report never carries a speed
  `SPTACH_ASSERT_NOW(a_stopped_zero, out_valid && out_stopped, out_rpm == '0)

  // every accepted item keeps the block busy in the next cycle
  `SPTACH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result stays put
  `SPTACH_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                      out_valid && $stable(out_rpm) && $stable(out_stopped))

endmodule

bind spark_tachometer_median_filter sptach_chk u_chk (.*);

>>> bench/spark_tachometer_median_filter_checker.sv
`timescale 1ns / 1ps

module spark_tachometer_median_filter_checker
  import sptach_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [TS_W-1:0]       in_now_cycles,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [RPM_OUT_W-1:0]  out_rpm,
  input  logic                  out_stopped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    results_owed
);

  localparam int DEPTH = SAMPLE_COUNT_DEF;
  localparam int MID   = DEPTH / 2;

  typedef struct {
    logic [RPM_OUT_W-1:0] rpm;
    logic                 stopped;
  } rpm_reading_t;

  logic [CPU_W-1:0] cpu_reg;
  logic [MIN_W-1:0] min_reg;
  logic [TMO_W-1:0] tmo_reg;
  logic [31:0]      rpm_store [DEPTH];
  logic [31:0]      last_spark;
  logic [31:0]      prev_rpm;
  logic             running;
  rpm_reading_t     readings_due [$];
  int               fault_tally = 0;

  function automatic logic [31:0] span_us(input logic [31:0] t);
    logic [31:0] div;
    div = (cpu_reg == '0) ? 32'd1 : {22'd0, cpu_reg};
    return (t - last_spark) / div;
  endfunction

  // sorted insert, dropping the far end from the insertion point
  task automatic insert_rpm(input logic [31:0] v);
    int pos;
    pos = 0;
    while (pos < DEPTH && v > rpm_store[pos]) pos++;
    if (pos < MID) begin
      for (int k = DEPTH - 1; k > pos; k--) rpm_store[k] = rpm_store[k-1];
      rpm_store[pos] = v;
    end else begin
      pos--;
      for (int k = 0; k < pos; k++) rpm_store[k] = rpm_store[k+1];
      rpm_store[pos] = v;
    end
  endtask

  task automatic apply_tach_item(input cmd_t c, input logic [31:0] t);
    rpm_reading_t r;
    logic [31:0]  us;
    logic [32:0]  sum;
    case (c)
      CMD_EDGE: begin
        if (running) begin
          us = span_us(t);
          if (us > {12'd0, min_reg}) begin
            last_spark = t;
            insert_rpm(RPM_NUM / us);
          end
        end
      end
      CMD_START: begin
        if (!running) begin
          foreach (rpm_store[i]) rpm_store[i] = '0;
          last_spark = t;
          prev_rpm   = '0;
          running    = 1'b1;
        end
      end
      CMD_STOP: begin
        running = 1'b0;
      end
      default: begin
        if (!running || span_us(t) > {5'd0, tmo_reg}) begin
          r.rpm     = '0;
          r.stopped = 1'b1;
        end else begin
          sum       = {1'b0, prev_rpm} + {1'b0, rpm_store[MID]};
          prev_rpm  = sum[32:1];
          r.rpm     = (prev_rpm > 32'hFFFF) ? 16'hFFFF : prev_rpm[15:0];
          r.stopped = 1'b0;
        end
        readings_due.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    rpm_reading_t want;
    if (!rst_n) begin
      cpu_reg    = CPU_RST;
      min_reg    = MIN_RST;
      tmo_reg    = TMO_RST;
      foreach (rpm_store[i]) rpm_store[i] = '0;
      last_spark = '0;
      prev_rpm   = '0;
      running    = 1'b0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_CPU: cpu_reg = cfg_wdata[CPU_W-1:0];
          CFG_IDX_MIN: min_reg = cfg_wdata[MIN_W-1:0];
          CFG_IDX_TMO: tmo_reg = cfg_wdata[TMO_W-1:0];
          default: ;
        endcase
      end
      // results first: an item taken at this edge cannot have its result yet
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $error("unexpected result item: rpm %0d stopped %0d", out_rpm, out_stopped);
          fault_tally++;
        end else begin
          want = readings_due.pop_front();
          if (out_rpm !== want.rpm) begin
            $error("rpm mismatch: expected %0d, actual %0d", want.rpm, out_rpm);
            fault_tally++;
          end
          if (out_stopped !== want.stopped) begin
            $error("stopped mismatch: expected %0d, actual %0d", want.stopped, out_stopped);
            fault_tally++;
          end
        end
      end
      if (in_valid && !in_stall) apply_tach_item(cmd_t'(in_cmd), in_now_cycles);
    end
    mismatch_count <= fault_tally;
    results_owed   <= readings_due.size();
  end

endmodule

>>> bench/tb_spark_tachometer_median_filter.sv
`timescale 1ns / 1ps

module tb_spark_tachometer_median_filter;
  import sptach_pkg::*;

  // random item budget per configuration phase, eight phases in all
  localparam int PHASE_TOTAL = 8;
  localparam int PHASE_QUOTA = 140;
  // edge items keep the block busy through two divides and an insert, so settle longer
  localparam int DRAIN_CYCLES = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_cmd = '0;
  logic [TS_W-1:0]       in_now_cycles = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RPM_OUT_W-1:0]  out_rpm;
  logic                  out_stopped;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatch_count;
  int                    results_owed;

  // stimulus-side view of the configuration and of the spark timeline,
  // only used to aim intervals; the checker keeps the real prediction
  longint unsigned tb_cpu = 360;
  longint unsigned tb_min = 3000;
  longint unsigned tb_tmo = 1000000;
  logic [31:0]     stim_last = '0;
  bit              stim_running = 1'b0;
  bit              calm = 1'b0;     // no idling on either side when set
  int              sent_count = 0;

  spark_tachometer_median_filter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_now_cycles (in_now_cycles),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rpm       (out_rpm),
    .out_stopped   (out_stopped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  spark_tachometer_median_filter_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_now_cycles  (in_now_cycles),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rpm        (out_rpm),
    .out_stopped    (out_stopped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit: several times the slowest legal run
  initial begin
    #20_000_000;
    $display("** spark_tachometer_median_filter: FAILED **");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // effective divider, zero counts as one
  function automatic longint unsigned eff_cpu();
    return (tb_cpu == 0) ? 1 : tb_cpu;
  endfunction

  // longest interval in us that still fits the 32-bit counter
  function automatic longint unsigned reach_us();
    return (64'h1_0000_0000 / eff_cpu()) - 1;
  endfunction

  // cycles whose quotient by the divider is exactly us
  function automatic logic [31:0] us_to_cycles(input longint unsigned us);
    longint unsigned cyc;
    cyc = us * eff_cpu() + $urandom_range(0, 32'(eff_cpu() - 1));
    return cyc[31:0];
  endfunction

  // one item; valid stays up while stalled, payload held
  task automatic send_item(input cmd_t c, input logic [31:0] t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_now_cycles <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // read mostly within the timeout, sometimes right at it or just past
  task automatic send_read();
    longint unsigned us;
    case ($urandom_range(0, 9))
      0: us = tb_tmo + 1 + $urandom_range(0, 3);
      1: us = tb_tmo;
      default: us = $urandom_range(0, 32'(tb_tmo));
    endcase
    if (us > reach_us()) us = reach_us();
    send_item(CMD_READ, stim_last + us_to_cycles(us));
  endtask

  // well-formed run: start, a train of spark edges with reads in between,
  // the odd bounce, and usually a stop at the end
  task automatic run_burst();
    logic [31:0]     t;
    longint unsigned us;
    int              n_edges;
    t = $urandom;
    send_item(CMD_START, t);
    if (!stim_running) begin
      stim_last    = t;
      stim_running = 1'b1;
    end
    n_edges = $urandom_range(8, 40);
    for (int k = 0; k < n_edges; k++) begin
      if ($urandom_range(0, 9) == 0)
        us = $urandom_range(0, 32'(tb_min));    // bounce, at or below the minimum
      else
        us = tb_min + 1 + $urandom_range(0, 32'(tb_min / 4 + 64));
      if (us > reach_us()) us = reach_us();
      t = stim_last + us_to_cycles(us);
      send_item(CMD_EDGE, t);
      if (us > tb_min) stim_last = t;
      if ($urandom_range(0, 3) == 0) send_read();
    end
    if ($urandom_range(0, 1) == 0) begin
      send_item(CMD_STOP, $urandom);
      stim_running = 1'b0;
    end
  endtask

  // any command at any time stamp
  task automatic send_noise();
    cmd_t        c;
    logic [31:0] t;
    c = cmd_t'($urandom_range(0, 3));
    t = $urandom;
    send_item(c, t);
    if (c == CMD_START && !stim_running) begin
      stim_last    = t;
      stim_running = 1'b1;
    end else if (c == CMD_STOP) begin
      stim_running = 1'b0;
    end
  endtask

  task automatic run_phase(input int quota);
    int goal;
    goal = sent_count + quota;
    while (sent_count < goal) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else run_burst();
    end
  endtask

  // drop valid, wait for every owed result, then let a pending edge finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // directed part under the reset configuration
  task automatic run_directed();
    logic [31:0] t;
    send_item(CMD_READ, 32'h0000_0000);   // read while inactive reports stopped
    send_item(CMD_EDGE, 32'hFFFF_FFFF);   // edge while inactive is ignored
    send_item(CMD_STOP, 32'h1234_5678);   // stop while inactive does nothing
    t = 32'hFFFF_F000;                    // first spark wraps the counter
    send_item(CMD_START, t);
    stim_last    = t;
    stim_running = 1'b1;
    send_item(CMD_START, 32'h0000_0000);  // start while running keeps the state
    send_item(CMD_READ, t);               // empty store, zero elapsed
    // exactly the minimum interval counts as bounce
    send_item(CMD_EDGE, t + 32'd1_080_000 + 32'd359);
    // fifteen sparks in mixed order fill the upper half of the store
    for (int k = 0; k < 15; k++) begin
      t = stim_last + 32'((3001 + ((k * 7) % 15) * 1500) * 360);
      send_item(CMD_EDGE, t);
      stim_last = t;
    end
    send_item(CMD_READ, stim_last + 32'd360_000);
    send_item(CMD_READ, stim_last + 32'd360_000_360);   // one us past the timeout
    send_item(CMD_STOP, 32'h0000_0000);
    stim_running = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(PHASE_QUOTA);

    for (int p = 1; p < PHASE_TOTAL; p++) begin
      settle();
      case (p)
        // tiny intervals: rpm saturates, timeout of one us
        1: begin tb_cpu = 1;    tb_min = 0;       tb_tmo = 1;         end
        // zero divider is taken as one
        2: begin tb_cpu = 0;    tb_min = 5;       tb_tmo = 1000;      end
        // every register at its field maximum
        3: begin tb_cpu = 1023; tb_min = 1048575; tb_tmo = 134217727; end
        4: begin tb_cpu = 1000; tb_min = 1000000; tb_tmo = 100000000; end
        5: begin tb_cpu = 360;  tb_min = 3000;    tb_tmo = 1000000;   end
        default: begin
          tb_cpu = $urandom_range(1, 1000);
          tb_min = $urandom_range(0, 20000);
          tb_tmo = $urandom_range(1000, 5000000);
        end
      endcase
      if (p == PHASE_TOTAL - 1) calm = 1'b1;   // last phase runs at full rate
      write_reg(CFG_IDX_CPU, tb_cpu);
      write_reg(CFG_IDX_MIN, tb_min);
      write_reg(CFG_IDX_TMO, tb_tmo);
      cfg_we <= 1'b0;
      run_phase(PHASE_QUOTA);
    end

    settle();
    if (mismatch_count == 0 && results_owed == 0)
      $display("** spark_tachometer_median_filter: PASSED **");
    else
      $display("** spark_tachometer_median_filter: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sptach_pkg.sv
rtl/sptach_ctrl.sv
rtl/sptach_dp.sv
rtl/spark_tachometer_median_filter.sv
rtl/sptach_chk.sv
bench/spark_tachometer_median_filter_checker.sv
bench/tb_spark_tachometer_median_filter.sv
